@@ rtl/linear_adrc_controller_assert.svh @@
// Assertion macros shared by the checker.
`ifndef LINEAR_ADRC_CONTROLLER_ASSERT_SVH
`define LINEAR_ADRC_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define LAC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define LAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/lac_pkg.sv @@
`timescale 1ns / 1ps
package lac_pkg;

    localparam int DW    = 32;
    localparam int FB    = 16;
    localparam int RW    = 31;
    localparam int QW    = DW + FB;
    localparam int CNT_W = 6;
    localparam int PC_W  = 6;
    localparam int NUM_UOPS = 41;

    localparam logic [2:0] CFG_BW  = 3'd0;
    localparam logic [2:0] CFG_TS  = 3'd1;
    localparam logic [2:0] CFG_KP  = 3'd2;
    localparam logic [2:0] CFG_KD  = 3'd3;
    localparam logic [2:0] CFG_B0  = 3'd4;
    localparam logic [2:0] CFG_R   = 3'd5;
    localparam logic [2:0] CFG_LIM = 3'd6;

    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} t_op;

    typedef enum logic [4:0] {
        SL_W, SL_TS, SL_KP, SL_KD, SL_B0, SL_R, SL_X, SL_Y,
        SL_TP, SL_TV, SL_OP, SL_OV, SL_OD, SL_LD,
        SL_T0, SL_T1, SL_T2, SL_T3, SL_T4, SL_T5, SL_T6, SL_T7
    } t_slot;

    typedef struct packed {
        t_op   op;
        t_slot a;
        t_slot b;
        t_slot dst;
    } t_uop;

    typedef struct packed {
        logic load;
        logic exec;
        logic wb;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic div_last;
        logic out_free;
    } t_sts;

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = '{OP_MUL, SL_R,  SL_R,  SL_T0};
            6'd1:  u = '{OP_SUB, SL_X,  SL_TP, SL_T1};
            6'd2:  u = '{OP_MUL, SL_T0, SL_T1, SL_T0};
            6'd3:  u = '{OP_MUL, SL_R,  SL_TV, SL_T1};
            6'd4:  u = '{OP_ADD, SL_T1, SL_T1, SL_T1};
            6'd5:  u = '{OP_SUB, SL_T0, SL_T1, SL_T0};
            6'd6:  u = '{OP_MUL, SL_TV, SL_TS, SL_T1};
            6'd7:  u = '{OP_MUL, SL_T0, SL_TS, SL_T2};
            6'd8:  u = '{OP_MUL, SL_T2, SL_TS, SL_T2};
            6'd9:  u = '{OP_ADD, SL_T1, SL_T2, SL_T1};
            6'd10: u = '{OP_MUL, SL_T0, SL_TS, SL_T2};
            6'd11: u = '{OP_ADD, SL_TP, SL_T1, SL_TP};
            6'd12: u = '{OP_ADD, SL_TV, SL_T2, SL_TV};
            6'd13: u = '{OP_ADD, SL_W,  SL_W,  SL_T0};
            6'd14: u = '{OP_ADD, SL_T0, SL_T0, SL_T0};
            6'd15: u = '{OP_ADD, SL_T0, SL_T0, SL_T1};
            6'd16: u = '{OP_ADD, SL_T1, SL_T0, SL_T1};
            6'd17: u = '{OP_MUL, SL_T1, SL_T0, SL_T2};
            6'd18: u = '{OP_MUL, SL_T0, SL_T0, SL_T3};
            6'd19: u = '{OP_MUL, SL_T3, SL_T0, SL_T3};
            6'd20: u = '{OP_SUB, SL_OP, SL_Y,  SL_T4};
            6'd21: u = '{OP_MUL, SL_T1, SL_T4, SL_T5};
            6'd22: u = '{OP_SUB, SL_OV, SL_T5, SL_T5};
            6'd23: u = '{OP_MUL, SL_T5, SL_TS, SL_T5};
            6'd24: u = '{OP_ADD, SL_OP, SL_T5, SL_T5};
            6'd25: u = '{OP_MUL, SL_T2, SL_T4, SL_T6};
            6'd26: u = '{OP_SUB, SL_OD, SL_T6, SL_T6};
            6'd27: u = '{OP_MUL, SL_B0, SL_LD, SL_T7};
            6'd28: u = '{OP_ADD, SL_T6, SL_T7, SL_T6};
            6'd29: u = '{OP_MUL, SL_T6, SL_TS, SL_T6};
            6'd30: u = '{OP_ADD, SL_OV, SL_T6, SL_OV};
            6'd31: u = '{OP_MUL, SL_T3, SL_T4, SL_T7};
            6'd32: u = '{OP_MUL, SL_T7, SL_TS, SL_T7};
            6'd33: u = '{OP_SUB, SL_OD, SL_T7, SL_OD};
            6'd34: u = '{OP_ADD, SL_T5, SL_W,  SL_OP};
            6'd35: u = '{OP_SUB, SL_TP, SL_OP, SL_T0};
            6'd36: u = '{OP_MUL, SL_KP, SL_T0, SL_T0};
            6'd37: u = '{OP_SUB, SL_TV, SL_OV, SL_T1};
            6'd38: u = '{OP_MUL, SL_KD, SL_T1, SL_T1};
            6'd39: u = '{OP_ADD, SL_T0, SL_T1, SL_T0};
            6'd40: u = '{OP_SUB, SL_T0, SL_OD, SL_T0};
            default: u = '{OP_ADD, SL_T0, SL_T0, SL_T0};
        endcase
        return u;
    endfunction

endpackage

@@ rtl/linear_adrc_controller.sv @@
// Each input beat runs 41 steps (an execute and a write-back state each) on one
// shared multiplier/adder, then the bit-serial divider and the output register;
// a clear beat goes straight to the output. A new beat is taken only when idle;
// the divider and multiplier set the pace. Result register frees the input side.
// Reset (i_rst_n, synchronous, low): state zero, registers at defaults.
`timescale 1ns / 1ps
module linear_adrc_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_setpoint,
    input  logic signed [31:0] i_measured,
    input  logic               i_clear,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_drive,
    output logic               o_clamped
);
    import lac_pkg::*;

    t_cmd            w_cmd;
    t_sts            w_sts;
    logic [PC_W-1:0] w_pc;

    lac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_pc       (w_pc),
        .o_busy     (o_in_stall)
    );

    lac_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_pc        (w_pc),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .i_clear     (i_clear),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_drive     (o_drive),
        .o_clamped   (o_clamped)
    );
endmodule

@@ rtl/lac_ctrl.sv @@
`timescale 1ns / 1ps
module lac_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  lac_pkg::t_sts        i_sts,
    output lac_pkg::t_cmd        o_cmd,
    output logic [lac_pkg::PC_W-1:0] o_pc,
    output logic                 o_busy
);
    import lac_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WB, S_DIV_INIT, S_DIV, S_DONE} t_state;

    t_state            r_state;
    logic [PC_W-1:0]   r_pc;
    logic              w_accept;

    assign w_accept = (r_state == S_IDLE) && i_in_valid;
    assign o_busy   = (r_state != S_IDLE);
    assign o_pc     = r_pc;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = w_accept;
        case (r_state)
            S_EXEC:     o_cmd.exec      = 1'b1;
            S_WB:       o_cmd.wb        = 1'b1;
            S_DIV_INIT: o_cmd.div_start = 1'b1;
            S_DIV:      o_cmd.div_step  = 1'b1;
            S_DONE:     o_cmd.finish    = i_sts.out_free;
            default:    o_cmd.exec      = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_pc <= '0;
                    if (w_accept) begin
                        // a clear beat has no arithmetic to run
                        r_state <= i_sts.is_clear ? S_DONE : S_EXEC;
                    end
                end
                S_EXEC: r_state <= S_WB;
                S_WB: begin
                    if (r_pc == PC_W'(NUM_UOPS - 1)) begin
                        r_state <= S_DIV_INIT;
                    end else begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= S_EXEC;
                    end
                end
                S_DIV_INIT: r_state <= S_DIV;
                S_DIV: begin
                    if (i_sts.div_last) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/lac_dp.sv @@
`timescale 1ns / 1ps
module lac_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lac_pkg::t_cmd               i_cmd,
    input  logic [lac_pkg::PC_W-1:0]    i_pc,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [31:0]                 i_cfg_data,
    input  logic signed [31:0]          i_setpoint,
    input  logic signed [31:0]          i_measured,
    input  logic                        i_clear,
    input  logic                        i_out_stall,
    output lac_pkg::t_sts               o_sts,
    output logic                        o_out_valid,
    output logic signed [31:0]          o_drive,
    output logic                        o_clamped
);
    import lac_pkg::*;

    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

    logic [RW-1:0]          r_bw, r_ts, r_b0, r_r, r_lim;
    logic signed [DW-1:0]   r_kp, r_kd;
    logic signed [DW-1:0]   r_x, r_y, r_tp, r_tv, r_op, r_ov, r_od, r_ld;
    logic signed [DW-1:0]   r_t [8];
    logic                   r_clr;
    logic signed [2*DW-1:0] r_prod;
    logic signed [DW:0]     r_sum;
    logic [QW-1:0]          r_dvd;
    logic [RW-1:0]          r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_dneg, r_dnz, r_dzero;
    logic                   r_out_valid, r_clamped;
    logic signed [DW-1:0]   r_drive;

    t_uop                   w_uop;
    logic signed [DW-1:0]   w_a, w_b, w_res;
    logic signed [2*DW-1:0] w_adj;
    logic signed [QW-1:0]   w_shr;
    logic [RW:0]            w_rem_sh;
    logic                   w_qbit;
    logic [RW:0]            w_rem_sub;
    logic signed [DW-1:0]   w_q, w_lim, w_u;
    logic                   w_clamp;
    logic [DW-1:0]          w_nmag;

    function automatic logic signed [DW-1:0] rd(input t_slot s);
        logic signed [DW-1:0] v;
        case (s)
            SL_W:  v = {1'b0, r_bw};
            SL_TS: v = {1'b0, r_ts};
            SL_KP: v = r_kp;
            SL_KD: v = r_kd;
            SL_B0: v = {1'b0, r_b0};
            SL_R:  v = {1'b0, r_r};
            SL_X:  v = r_x;
            SL_Y:  v = r_y;
            SL_TP: v = r_tp;
            SL_TV: v = r_tv;
            SL_OP: v = r_op;
            SL_OV: v = r_ov;
            SL_OD: v = r_od;
            SL_LD: v = r_ld;
            SL_T0: v = r_t[0];
            SL_T1: v = r_t[1];
            SL_T2: v = r_t[2];
            SL_T3: v = r_t[3];
            SL_T4: v = r_t[4];
            SL_T5: v = r_t[5];
            SL_T6: v = r_t[6];
            SL_T7: v = r_t[7];
            default: v = '0;
        endcase
        return v;
    endfunction

    assign w_uop = uop_rom(i_pc);
    // move to OP is encoded as T5 + W; B slot is ignored for that step below
    assign w_a   = rd(w_uop.a);
    assign w_b   = (w_uop.dst == SL_OP && w_uop.a == SL_T5) ? '0 : rd(w_uop.b);

    // product truncated toward zero, then saturated
    always_comb begin
        w_adj = r_prod + (r_prod[2*DW-1] ? (2*DW)'((64'd1 << FB) - 64'd1) : '0);
        w_shr = QW'(w_adj >>> FB);
        w_res = r_sum[DW-1:0];
        case (w_uop.op)
            OP_MUL: begin
                if (w_shr > QW'(VMAX))      w_res = VMAX;
                else if (w_shr < QW'(VMIN)) w_res = VMIN;
                else                        w_res = w_shr[DW-1:0];
            end
            OP_ADD, OP_SUB: begin
                if (r_sum[DW] != r_sum[DW-1]) w_res = r_sum[DW] ? VMIN : VMAX;
            end
            default: w_res = r_sum[DW-1:0];
        endcase
    end

    // restoring divider, one quotient bit per cycle
    assign w_rem_sh  = {r_rem, r_dvd[QW-1]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_b0});
    assign w_rem_sub = w_rem_sh - {1'b0, r_b0};
    assign w_nmag    = r_t[0][DW-1] ? (~r_t[0] + 1'b1) : r_t[0];

    always_comb begin
        if (r_dzero || r_dvd > QW'(VMAX)) begin
            w_q = !r_dnz ? '0 : (r_dneg ? VMIN : VMAX);
        end else begin
            w_q = r_dneg ? -$signed(r_dvd[DW-1:0]) : $signed(r_dvd[DW-1:0]);
        end
        w_lim   = {1'b0, r_lim};
        w_u     = w_q;
        w_clamp = 1'b0;
        if (w_q > w_lim) begin
            w_u = w_lim;
            w_clamp = 1'b1;
        end else if (w_q < -w_lim) begin
            w_u = -w_lim;
            w_clamp = 1'b1;
        end
    end

    assign o_sts.is_clear = i_clear;
    assign o_sts.div_last = (r_cnt == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_drive        = r_drive;
    assign o_clamped      = r_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw  <= RW'(6553600);
            r_ts  <= RW'(66);
            r_kp  <= DW'(65536);
            r_kd  <= '0;
            r_b0  <= RW'(65536);
            r_r   <= RW'(655360);
            r_lim <= RW'(589824);
            r_tp  <= '0;
            r_tv  <= '0;
            r_op  <= '0;
            r_ov  <= '0;
            r_od  <= '0;
            r_ld  <= '0;
            r_out_valid <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BW:  r_bw  <= i_cfg_data[RW-1:0];
                    CFG_TS:  r_ts  <= i_cfg_data[RW-1:0];
                    CFG_KP:  r_kp  <= i_cfg_data;
                    CFG_KD:  r_kd  <= i_cfg_data;
                    CFG_B0:  r_b0  <= i_cfg_data[RW-1:0];
                    CFG_R:   r_r   <= i_cfg_data[RW-1:0];
                    CFG_LIM: r_lim <= i_cfg_data[RW-1:0];
                    default: r_bw  <= r_bw;
                endcase
            end
            if (i_cmd.load) begin
                r_x   <= i_setpoint;
                r_y   <= i_measured;
                r_clr <= i_clear;
            end
            if (i_cmd.exec) begin
                r_prod <= w_a * w_b;
                r_sum  <= (w_uop.op == OP_SUB) ? ({w_a[DW-1], w_a} - {w_b[DW-1], w_b})
                                               : ({w_a[DW-1], w_a} + {w_b[DW-1], w_b});
            end
            if (i_cmd.wb) begin
                case (w_uop.dst)
                    SL_TP: r_tp <= w_res;
                    SL_TV: r_tv <= w_res;
                    SL_OP: r_op <= w_res;
                    SL_OV: r_ov <= w_res;
                    SL_OD: r_od <= w_res;
                    SL_T0: r_t[0] <= w_res;
                    SL_T1: r_t[1] <= w_res;
                    SL_T2: r_t[2] <= w_res;
                    SL_T3: r_t[3] <= w_res;
                    SL_T4: r_t[4] <= w_res;
                    SL_T5: r_t[5] <= w_res;
                    SL_T6: r_t[6] <= w_res;
                    SL_T7: r_t[7] <= w_res;
                    default: r_t[0] <= r_t[0];
                endcase
            end
            if (i_cmd.div_start) begin
                r_dvd   <= {w_nmag, {FB{1'b0}}};
                r_rem   <= '0;
                r_cnt   <= CNT_W'(QW - 1);
                r_dneg  <= r_t[0][DW-1];
                r_dnz   <= (r_t[0] != '0);
                r_dzero <= (r_b0 == '0);
            end
            if (i_cmd.div_step) begin
                r_rem <= w_qbit ? w_rem_sub[RW-1:0] : w_rem_sh[RW-1:0];
                r_dvd <= {r_dvd[QW-2:0], w_qbit};
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (r_clr) begin
                    r_tp <= '0;
                    r_tv <= '0;
                    r_op <= '0;
                    r_ov <= '0;
                    r_od <= '0;
                    r_ld <= '0;
                    r_drive   <= '0;
                    r_clamped <= 1'b0;
                end else begin
                    r_ld      <= w_u;
                    r_drive   <= w_u;
                    r_clamped <= w_clamp;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule

@@ rtl/lac_checker.sv @@
`timescale 1ns / 1ps
`include "linear_adrc_controller_assert.svh"
module lac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_drive,
    input logic        o_clamped
);
    // a held result keeps its value
    `LAC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_drive) && $stable(o_clamped))
    // accepting a beat makes the block busy
    `LAC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    // results only appear at the end of work in progress
    `LAC_ASSERT_NOW(a_result_from_work, $rose(o_out_valid), $past(o_in_stall))
endmodule

bind linear_adrc_controller lac_checker u_lac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_drive     (o_drive),
    .o_clamped   (o_clamped)
);

@@ dv/tb_linear_adrc_controller.sv @@
`timescale 1ns / 1ps
module tb_linear_adrc_controller;
    import lac_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam longint ONE = 64'sd65536;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 140;

    typedef struct {
        logic signed [31:0] drive;
        logic               clamped;
    } t_drive_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = CFG_BW;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_setpoint = '0;
    logic signed [31:0] i_measured = '0;
    logic               i_clear = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_drive;
    logic               o_clamped;

    linear_adrc_controller i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] cfg_mirror [7];
    longint trk_pos, trk_vel, est_pos, est_vel, est_dist, prev_drive;
    t_drive_beat drive_expect [$];

    int     cycle = 0;
    int     hold_until = 0;
    int     mismatches = 0;
    int     ticks_sent = 0;
    int     clamps_seen = 0;
    int     clears_sent = 0;
    bit     quiet = 1'b0;
    int     out_burst = 0;

    function automatic longint sat_q(longint v);
        return v > Q_MAX ? Q_MAX : (v < Q_MIN ? Q_MIN : v);
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        p = p < 0 ? -((-p) >>> 16) : p >>> 16;
        return sat_q(p);
    endfunction

    function automatic longint qdiv(longint n, longint d);
        longint m, q;
        if (n == 0) return 0;
        if (d <= 0) return n < 0 ? Q_MIN : Q_MAX;
        m = n < 0 ? -n : n;
        q = (m <<< 16) / d;
        return sat_q(n < 0 ? -q : q);
    endfunction

    function automatic longint cfg_val(logic [2:0] idx);
        if (idx == CFG_KP || idx == CFG_KD) return longint'(signed'(cfg_mirror[idx]));
        return longint'({1'b0, cfg_mirror[idx][30:0]});
    endfunction

    function automatic void reset_mirror();
        cfg_mirror[CFG_BW] = 32'd6553600;
        cfg_mirror[CFG_TS] = 32'd66;
        cfg_mirror[CFG_KP] = 32'd65536;
        cfg_mirror[CFG_KD] = 32'd0;
        cfg_mirror[CFG_B0] = 32'd65536;
        cfg_mirror[CFG_R] = 32'd655360;
        cfg_mirror[CFG_LIM] = 32'd589824;
    endfunction

    function automatic t_drive_beat adrc_tick(longint sp, longint meas, bit clr);
        longint w, ts, kp, kd, b0, r, lim;
        longint fh, w0, b1, b2, b3, e, npos, nvel, ndist, pd, u;
        t_drive_beat res;
        w = cfg_val(CFG_BW); ts = cfg_val(CFG_TS); kp = cfg_val(CFG_KP);
        kd = cfg_val(CFG_KD); b0 = cfg_val(CFG_B0); r = cfg_val(CFG_R);
        lim = cfg_val(CFG_LIM);
        res.clamped = 1'b0;
        if (clr) begin
            trk_pos = 0; trk_vel = 0; est_pos = 0; est_vel = 0; est_dist = 0;
            prev_drive = 0;
            res.drive = '0;
            return res;
        end
        fh = sat_q(qmul(qmul(r, r), sat_q(sp - trk_pos))
                   - sat_q(qmul(r, trk_vel) + qmul(r, trk_vel)));
        trk_pos = sat_q(trk_pos + sat_q(qmul(trk_vel, ts) + qmul(qmul(fh, ts), ts)));
        trk_vel = sat_q(trk_vel + qmul(fh, ts));
        w0 = sat_q(sat_q(w + w) + sat_q(w + w));
        b1 = sat_q(sat_q(w0 + w0) + w0);
        b2 = qmul(b1, w0);
        b3 = qmul(qmul(w0, w0), w0);
        e = sat_q(est_pos - meas);
        npos = sat_q(est_pos + qmul(sat_q(est_vel - qmul(b1, e)), ts));
        nvel = sat_q(est_vel + qmul(sat_q(sat_q(est_dist - qmul(b2, e))
                                           + qmul(b0, prev_drive)), ts));
        ndist = sat_q(est_dist - qmul(qmul(b3, e), ts));
        est_pos = npos; est_vel = nvel; est_dist = ndist;
        pd = sat_q(qmul(kp, sat_q(trk_pos - est_pos)) + qmul(kd, sat_q(trk_vel - est_vel)));
        u = qdiv(sat_q(pd - est_dist), b0);
        if (u > lim) begin
            u = lim; res.clamped = 1'b1;
        end else if (u < -lim) begin
            u = -lim; res.clamped = 1'b1;
        end
        prev_drive = u;
        res.drive = u[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle);
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stall bursts plus the long hold-off window
    always @(posedge i_clk) begin
        if (cycle < hold_until) begin
            i_out_stall <= 1'b1;
        end else if (out_burst > 0) begin
            i_out_stall <= 1'b1;
            out_burst <= out_burst - 1;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            i_out_stall <= 1'b1;
            out_burst <= $urandom_range(0, 11);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_drive_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_expect.size() == 0) begin
                report_mismatch("unexpected beat, drive", o_drive, 0);
            end else begin
                want = drive_expect.pop_front();
                if (o_drive !== want.drive) report_mismatch("drive", o_drive, want.drive);
                if (o_clamped !== want.clamped)
                    report_mismatch("clamped", o_clamped, want.clamped);
                if (want.clamped) clamps_seen++;
            end
        end
    end

    task automatic send_tick(logic [31:0] sp, logic [31:0] meas, bit clr);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_setpoint <= sp;
        i_measured <= meas;
        i_clear <= clr;
        do @(posedge i_clk); while (o_in_stall);
        drive_expect.push_back(adrc_tick(longint'(signed'(sp)), longint'(signed'(meas)), clr));
        ticks_sent++;
        if (clr) clears_sent++;
    endtask

    // drain, then leave the pipe alone long enough to be truly idle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (drive_expect.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= CFG_LIM) cfg_mirror[idx] = data;
    endtask

    function automatic logic [31:0] rand_q16(int spread);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'(int'($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] edge_vals [5] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h10000};
        send_tick(32'h0, 32'h0, 1'b1);
        foreach (edge_vals[i]) send_tick(edge_vals[i], edge_vals[4 - i], 1'b0);
        send_tick(32'h7fffffff, 32'h80000000, 1'b1);
        send_tick(32'h00050000, 32'h0, 1'b0);
        send_tick(32'h00050000, 32'h00010000, 1'b0);
        wait_idle();
        // zero plant gain and a write to an unused index
        write_reg(CFG_B0, 32'h0);
        write_reg(CFG_UNUSED, 32'hffffffff);
        send_tick(32'h00030000, 32'hfffd0000, 1'b0);
        send_tick(32'h80000000, 32'h7fffffff, 1'b0);
        send_tick(32'h0, 32'h0, 1'b1);
        send_tick(32'h0, 32'h0, 1'b0);
        wait_idle();
        // zero limit, then full-scale limit and gains
        write_reg(CFG_B0, 32'h00010000);
        write_reg(CFG_LIM, 32'h0);
        send_tick(32'h00020000, 32'h0, 1'b0);
        send_tick(32'hfffe0000, 32'h0, 1'b0);
        wait_idle();
        write_reg(CFG_LIM, 32'hffffffff);
        write_reg(CFG_KP, 32'h80000000);
        write_reg(CFG_KD, 32'h7fffffff);
        write_reg(CFG_BW, 32'h7fffffff);
        write_reg(CFG_TS, 32'h7fffffff);
        write_reg(CFG_R, 32'h7fffffff);
        send_tick(32'h7fffffff, 32'h0, 1'b0);
        send_tick(32'h80000000, 32'h12345678, 1'b0);
        send_tick(32'h0, 32'h0, 1'b1);
        wait_idle();
    endtask

    task automatic program_random_cfg(bit wide);
        write_reg(CFG_BW, wide ? $urandom() : $urandom_range(0, 40 * ONE));
        write_reg(CFG_TS, wide ? $urandom() : $urandom_range(0, 3000));
        write_reg(CFG_KP, wide ? $urandom() : 32'(int'($urandom_range(0, 40 * ONE)) - 8 * ONE));
        write_reg(CFG_KD, wide ? $urandom() : 32'(int'($urandom_range(0, 8 * ONE)) - 2 * ONE));
        write_reg(CFG_B0, wide ? $urandom() : $urandom_range(1, 20 * ONE));
        write_reg(CFG_R, wide ? $urandom() : $urandom_range(0, 60 * ONE));
        write_reg(CFG_LIM, wide ? $urandom() : $urandom_range(0, 200 * ONE));
    endtask

    // runs of steady setpoints with a noisy measurement, a few step changes
    task automatic test_tracking(int n_ticks, bit wide);
        logic [31:0] target;
        int spread;
        spread = wide ? 2000000000 : 16 * ONE;
        target = rand_q16(spread);
        program_random_cfg(wide);
        repeat (n_ticks) begin
            if ($urandom_range(0, 29) == 0) target = rand_q16(spread);
            if ($urandom_range(0, 19) == 0)
                send_tick($urandom(), $urandom(), $urandom_range(0, 3) == 0);
            else
                send_tick(target, target + 32'(int'($urandom_range(0, 4096)) - 2048),
                          $urandom_range(0, 39) == 0);
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_until = cycle + 1500;
        repeat (8) send_tick(rand_q16(4 * ONE), rand_q16(4 * ONE), 1'b0);
        wait_idle();
    endtask

    initial begin
        int guard;
        reset_mirror();
        trk_pos = 0; trk_vel = 0; est_pos = 0; est_vel = 0; est_dist = 0; prev_drive = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_tracking(300, 1'b0);
        test_tracking(200, 1'b1);
        test_tracking(300, 1'b0);
        test_tracking(250, 1'b0);
        quiet = 1'b1;
        test_tracking(270, 1'b0);
        guard = 0;
        while (drive_expect.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d ticks (%0d clears, %0d clamped drives) over several gain sets",
                 ticks_sent, clears_sent, clamps_seen);
        if (mismatches == 0 && drive_expect.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/lac_pkg.sv
rtl/lac_ctrl.sv
rtl/lac_dp.sv
rtl/linear_adrc_controller.sv
rtl/lac_checker.sv
dv/tb_linear_adrc_controller.sv
